@@ hdl/ali_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ali_pkg;

    localparam int CAPACITY      = 32;
    localparam int ELEMENT_WIDTH = 32;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 6;
    localparam int RD_W     = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam int IN_DATA_W  = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((LEN_W + RD_W + 7) / 8) * 8;

    typedef logic [ELEMENT_WIDTH-1:0] elem_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // per-item command broadcast to every cell
    typedef struct packed {
        logic  ins;
        logic  del;
        logic  rd;
        idx_t  pos;
        elem_t value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/ali_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ali_cell (
    input  logic               clk,
    input  ali_pkg::cell_ctrl_t ctrl,
    input  ali_pkg::idx_t      idx,
    input  ali_pkg::elem_t     prev_data,
    input  ali_pkg::elem_t     next_data,
    output ali_pkg::elem_t     data,
    output ali_pkg::elem_t     rd_data
);
    import ali_pkg::*;

    elem_t data_reg;
    elem_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (idx == ctrl.pos)
                data_next = ctrl.value;
            else if (idx > ctrl.pos)
                data_next = prev_data;
        end
        else if (ctrl.del)
        begin
            if (idx >= ctrl.pos)
                data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (ctrl.rd && (idx == ctrl.pos)) ? data_reg : '0;

endmodule

`default_nettype wire

@@ hdl/array_list_insert_delete.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY entries kept in a row of cells, one entry per
// cell. On an insert or a delete, every cell loads from its left or right
// neighbor in the same clock, so a whole shift completes at once. A new item
// is accepted every cycle while the result register is free or being drained;
// the result is registered and is valid in the cycle after acceptance. No
// clearing pass after reset. Input item: tuser = kind, tdata = position,
// value. Result item: tuser = status, tdata = length, read_value.
module array_list_insert_delete (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [5:0] position, [37:6] value, [39:38] zero
    input  logic [ali_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [ali_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [5:0] length, [37:6] read_value, [39:38] zero
    output logic [ali_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [ali_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import ali_pkg::*;

    logic                s_fire;
    kind_t               in_kind;
    logic [POS_W-1:0]    in_pos;
    logic [VALUE_W-1:0]  in_value;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;

    status_t             status;
    logic                ins_ok;
    logic                del_ok;
    logic                rd_ok;
    cell_ctrl_t          ctrl;

    cnt_t                count_reg;
    cnt_t                count_next;

    logic                m_valid_reg;
    status_t             status_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [RD_W-1:0]     rdval_reg;

    elem_t               cell_data [CAPACITY];
    elem_t               cell_rd   [CAPACITY];
    elem_t               rd_or;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign in_kind  = kind_t'(s_axis_tuser);
    assign in_pos   = s_axis_tdata[POS_W-1:0];
    assign in_value = s_axis_tdata[POS_W +: VALUE_W];
    assign pos_ext  = CMP_W'(in_pos);
    assign cnt_ext  = CMP_W'(count_reg);

    always_comb
    begin
        status = ST_OK;
        ins_ok = 1'b0;
        del_ok = 1'b0;
        rd_ok  = 1'b0;
        unique case (in_kind)
            KIND_INSERT:
            begin
                if (count_reg == CNT_W'(CAPACITY))
                    status = ST_FULL;
                else if (pos_ext > cnt_ext)
                    status = ST_RANGE;
                else
                    ins_ok = 1'b1;
            end
            KIND_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                    status = ST_RANGE;
                else
                    del_ok = 1'b1;
            end
            KIND_READ:
            begin
                if (pos_ext >= cnt_ext)
                    status = ST_RANGE;
                else
                    rd_ok = 1'b1;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        ctrl.ins   = s_fire && ins_ok;
        ctrl.del   = s_fire && del_ok;
        ctrl.rd    = rd_ok;
        ctrl.pos   = IDX_W'(in_pos);
        ctrl.value = elem_t'(in_value);
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.del)
            count_next = count_reg - CNT_W'(1);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            elem_t prev_d;
            elem_t next_d;

            if (gi == 0)
            begin : g_first
                assign prev_d = cell_data[gi];
            end
            else
            begin : g_mid_l
                assign prev_d = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign next_d = cell_data[gi+1];
            end

            ali_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .idx       (IDX_W'(gi)),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[gi]),
                .rd_data   (cell_rd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_or = rd_or | cell_rd[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_fire)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            status_reg <= status;
            len_reg    <= LEN_W'(count_next);
            rdval_reg  <= RD_W'(rd_or);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - LEN_W - RD_W){1'b0}}, rdval_reg, len_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow list");

    a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.del |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink list");

    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && status != ST_OK |=> count_reg == $past(count_reg))
        else $error("failed item changed list length");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && status_reg != ST_OK |-> rdval_reg == '0)
        else $error("read value on failed item");

endmodule

`default_nettype wire
